>>> rtl/rocs_pkg.sv
// Package for the relay-open check and three-phase sine reference block.
// Holds the request and result types, register indexes and default constants.
// Used by the top level and the testbench; depends on nothing else.
`default_nettype none

package rocs_pkg;

    localparam int PHASES = 3;

    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int COUNT_LIMIT_DEF      = 100;
    localparam int MIN_PULSE_DEF        = 9;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_VOLT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD           = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_AMPLITUDE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP           = 2'd3;

    localparam logic [14:0] THRESHOLD_RESET = 15'd500;
    localparam logic [14:0] PERIOD_RESET    = 15'd1000;
    localparam logic [14:0] AMPLITUDE_RESET = 15'd900;
    localparam logic [15:0] STEP_RESET      = 16'd164;

    localparam logic [15:0] ACC_RESET [PHASES] = '{16'd0, 16'd21845, 16'd43691};

    typedef struct packed {
        logic signed [15:0] inv_volt_r;
        logic signed [15:0] inv_volt_s;
        logic signed [15:0] inv_volt_t;
        logic signed [15:0] grid_volt_r;
        logic signed [15:0] grid_volt_s;
        logic signed [15:0] grid_volt_t;
    } sample_t;

    typedef struct packed {
        logic               all_open;
        logic [2:0]         open_flags;
        logic signed [15:0] vref_r;
        logic signed [15:0] vref_s;
        logic signed [15:0] vref_t;
        logic signed [15:0] iref_r;
        logic signed [15:0] iref_s;
        logic signed [15:0] iref_t;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/rocs_sine_rom.sv
// Sine lookup ROM with a registered read port, contents Q1.15.
// The table is built at elaboration from a Taylor series in Q2.30.
// Standalone; instantiated once per phase by the top level.
`default_nettype none

module rocs_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0]   addr,
    output logic signed [15:0]                         data
);

    typedef logic signed [15:0] rom_array_t [SINE_TABLE_DEPTH];

    localparam longint unsigned Q30_ONE    = 64'd1073741824;
    localparam longint unsigned Q30_HALFPI = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

    function automatic logic signed [15:0] sine_entry(input longint unsigned t);
        logic [1:0]        quad;
        longint unsigned   r;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   val;
        longint            sum;
        quad = 2'((t >> 30) & 64'd3);
        r    = t & (Q30_ONE - 64'd1);
        if (quad[0])
        begin
            r = Q30_ONE - r;
        end
        x    = (r * Q30_HALFPI) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 0; k < 5; k++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if ((k % 2) == 0)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        val = (longint'(sum) * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (val > 64'd32767)
        begin
            val = 64'd32767;
        end
        return quad[1] ? -$signed(16'(val)) : $signed(16'(val));
    endfunction

    function automatic rom_array_t build_rom();
        rom_array_t tab;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            tab[i] = sine_entry((longint'(i) << 32) / SINE_TABLE_DEPTH);
        end
        return tab;
    endfunction

    localparam rom_array_t ROM = build_rom();

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data <= ROM[addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/relay_open_check_three_phase_sine_ref_unit.sv
// Relay-open check with three-phase sine reference generation, top level.
// Depends on rocs_pkg and rocs_sine_rom.
//
// Each request is one control tick with three inverter-side and three grid-side
// voltages, and each gives exactly one result. A new request can be taken every
// cycle while the output is not stalled. The path runs through an input
// register, the counter and phase accumulator update, a registered sine ROM
// read (one ROM copy per phase), the amplitude multiply, and the clamp and
// rounding into the result register, which also holds the references between
// open ticks. Configuration writes are always ready and must only be made while
// the block is idle.
`default_nettype none

module relay_open_check_three_phase_sine_ref_unit #(
    parameter int SINE_TABLE_DEPTH = rocs_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int COUNT_LIMIT      = rocs_pkg::COUNT_LIMIT_DEF,
    parameter int MIN_PULSE        = rocs_pkg::MIN_PULSE_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                sample_valid,
    output logic                                     sample_stall,
    input  wire rocs_pkg::sample_t                   sample,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output rocs_pkg::result_t                        result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rocs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rocs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import rocs_pkg::*;

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

    logic [14:0] thr_reg;
    logic [14:0] period_reg;
    logic [14:0] amp_reg;
    logic [15:0] step_reg;

    logic        v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic        go0, go1, go2, go3;
    logic        free0, free1, free2, free3, out_free;

    sample_t     samp_reg;
    logic [6:0]  cnt_reg   [PHASES];
    logic [6:0]  cnt_next  [PHASES];
    logic [2:0]  flag_reg;
    logic [2:0]  flag_next;
    logic [15:0] acc_reg   [PHASES];
    logic [15:0] acc_next  [PHASES];
    logic        all_next;

    logic        all1_reg, all2_reg, all3_reg;
    logic [2:0]  flags1_reg, flags2_reg, flags3_reg;

    logic signed [15:0] inv_v  [PHASES];
    logic signed [15:0] grid_v [PHASES];
    logic signed [15:0] sine2  [PHASES];
    logic signed [15:0] sine3_reg [PHASES];
    logic signed [31:0] prod3_reg [PHASES];
    logic signed [15:0] vref_new  [PHASES];

    result_t     result_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THRESHOLD_RESET;
            period_reg <= PERIOD_RESET;
            amp_reg    <= AMPLITUDE_RESET;
            step_reg   <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RELAY_VOLT_THRESHOLD: thr_reg    <= cfg_data[14:0];
                CFG_PWM_PERIOD:           period_reg <= cfg_data[14:0];
                CFG_VOLTAGE_AMPLITUDE:    amp_reg    <= cfg_data[14:0];
                CFG_ANGLE_STEP:           step_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Each stage moves on when the next one is empty or moving on itself.
    assign out_free = !v4_reg || !result_stall;
    assign go3      = v3_reg && out_free;
    assign free3    = !v3_reg || go3;
    assign go2      = v2_reg && free3;
    assign free2    = !v2_reg || go2;
    assign go1      = v1_reg && free2;
    assign free1    = !v1_reg || go1;
    assign go0      = v0_reg && free1;
    assign free0    = !v0_reg || go0;

    assign sample_stall = !free0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (sample_valid && free0)
            begin
                v0_reg <= 1'b1;
            end
            else if (go0)
            begin
                v0_reg <= 1'b0;
            end
            if (go0)
            begin
                v1_reg <= 1'b1;
            end
            else if (go1)
            begin
                v1_reg <= 1'b0;
            end
            if (go1)
            begin
                v2_reg <= 1'b1;
            end
            else if (go2)
            begin
                v2_reg <= 1'b0;
            end
            if (go2)
            begin
                v3_reg <= 1'b1;
            end
            else if (go3)
            begin
                v3_reg <= 1'b0;
            end
            if (go3)
            begin
                v4_reg <= 1'b1;
            end
            else if (out_free)
            begin
                v4_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && free0)
        begin
            samp_reg <= sample;
        end
    end

    assign inv_v[0]  = samp_reg.inv_volt_r;
    assign inv_v[1]  = samp_reg.inv_volt_s;
    assign inv_v[2]  = samp_reg.inv_volt_t;
    assign grid_v[0] = samp_reg.grid_volt_r;
    assign grid_v[1] = samp_reg.grid_volt_s;
    assign grid_v[2] = samp_reg.grid_volt_t;

    always_comb
    begin
        logic signed [16:0] diff;
        logic [16:0]        abs_diff;
        logic [7:0]         cnt_sum;
        for (int p = 0; p < PHASES; p++)
        begin
            diff     = 17'(inv_v[p]) - 17'(grid_v[p]);
            abs_diff = diff[16] ? 17'(-diff) : 17'(diff);
            cnt_sum  = (abs_diff > {2'b00, thr_reg}) ? ({1'b0, cnt_reg[p]} + 8'd1) : 8'd0;
            if (cnt_sum > 8'(COUNT_LIMIT))
            begin
                cnt_next[p]  = 7'(COUNT_LIMIT + 1);
                flag_next[p] = 1'b1;
            end
            else
            begin
                cnt_next[p]  = cnt_sum[6:0];
                flag_next[p] = flag_reg[p];
            end
        end
        all_next = &flag_next;
        for (int p = 0; p < PHASES; p++)
        begin
            acc_next[p] = all_next ? (acc_reg[p] + step_reg) : acc_reg[p];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PHASES; p++)
            begin
                cnt_reg[p] <= 7'd0;
                acc_reg[p] <= ACC_RESET[p];
            end
            flag_reg <= 3'b000;
        end
        else if (go0)
        begin
            for (int p = 0; p < PHASES; p++)
            begin
                cnt_reg[p] <= cnt_next[p];
                acc_reg[p] <= acc_next[p];
            end
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go0)
        begin
            all1_reg   <= all_next;
            flags1_reg <= flag_next;
        end
        if (go1)
        begin
            all2_reg   <= all1_reg;
            flags2_reg <= flags1_reg;
        end
        if (go2)
        begin
            all3_reg   <= all2_reg;
            flags3_reg <= flags2_reg;
            for (int p = 0; p < PHASES; p++)
            begin
                sine3_reg[p] <= sine2[p];
                prod3_reg[p] <= 32'($signed({1'b0, amp_reg})) * 32'(sine2[p]);
            end
        end
    end

    // While an item sits in stage one, the accumulators hold its values.
    for (genvar p = 0; p < PHASES; p++)
    begin : g_phase
        logic [31:0] idx_prod;

        assign idx_prod = 32'(acc_reg[p]) * 32'(SINE_TABLE_DEPTH);

        rocs_sine_rom #(
            .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
        ) u_rom (
            .clk  (clk),
            .en   (go1),
            .addr (idx_prod[16 +: IDX_W]),
            .data (sine2[p])
        );
    end

    always_comb
    begin
        logic signed [16:0] lim_l;
        logic signed [32:0] lim_pos;
        logic signed [32:0] lim_neg;
        logic signed [32:0] scaled;
        logic signed [32:0] mag;
        lim_l   = $signed({2'b00, period_reg}) - 17'(MIN_PULSE);
        lim_pos = {lim_l[16], lim_l, 15'd0};
        lim_neg = -lim_pos;
        for (int p = 0; p < PHASES; p++)
        begin
            scaled = 33'(prod3_reg[p]);
            if (scaled > lim_pos)
            begin
                scaled = lim_pos;
            end
            else if (scaled < lim_neg)
            begin
                scaled = lim_neg;
            end
            if (scaled > 0)
            begin
                mag         = (scaled + 33'sd16384) >>> 15;
                vref_new[p] = 16'(mag);
            end
            else
            begin
                mag         = (-scaled + 33'sd16384) >>> 15;
                vref_new[p] = 16'(-mag);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (go3)
        begin
            result_reg.all_open   <= all3_reg;
            result_reg.open_flags <= flags3_reg;
            if (all3_reg)
            begin
                result_reg.vref_r <= vref_new[0];
                result_reg.vref_s <= vref_new[1];
                result_reg.vref_t <= vref_new[2];
                result_reg.iref_r <= sine3_reg[0];
                result_reg.iref_s <= sine3_reg[1];
                result_reg.iref_t <= sine3_reg[2];
            end
        end
    end

    assign result_valid = v4_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // Open flags never clear once set.
    a_flags_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (flag_reg & $past(flag_reg)) == $past(flag_reg))
        else $error("open flag cleared");

    // Counters saturate one past the limit.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= 7'(COUNT_LIMIT + 1) && cnt_reg[1] <= 7'(COUNT_LIMIT + 1)
        && cnt_reg[2] <= 7'(COUNT_LIMIT + 1))
        else $error("open counter beyond saturation");

    // Phase accumulators move only once all relays are open.
    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg[0] != $past(acc_reg[0]) || acc_reg[1] != $past(acc_reg[1])
        || acc_reg[2] != $past(acc_reg[2])) |-> (&flag_reg))
        else $error("phase accumulator advanced with a relay closed");

    // A delivered result reports all open exactly when every flag is set.
    a_all_open: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.all_open == (&result.open_flags)))
        else $error("all_open disagrees with open_flags");
`endif

endmodule

`default_nettype wire

>>> dv/tb_relay_open_check_three_phase_sine_ref_unit.sv
`timescale 1ns / 1ps
// Testbench for the relay-open check and three-phase sine reference unit.
// It predicts every result from its own model of the counters, flags and sine
// path and checks it against the block. It depends on rocs_pkg and the unit.

module tb_relay_open_check_three_phase_sine_ref_unit;

    import rocs_pkg::*;

    localparam int DEPTH          = SINE_TABLE_DEPTH_DEF;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 40;

    localparam longint unsigned Q30_ONE    = 64'd1073741824;
    localparam longint unsigned Q30_HALFPI = 64'd1686629713;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    sample_t               sample = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [14:0] thr_cfg;
    logic [14:0] period_cfg;
    logic [14:0] amp_cfg;
    logic [15:0] step_cfg;

    int unsigned        run_len [PHASES];
    bit [2:0]           open_state;
    logic [15:0]        angle [PHASES];
    logic signed [15:0] held_v [PHASES];
    logic signed [15:0] held_i [PHASES];
    logic signed [15:0] sine_tab [DEPTH];

    result_t pending_refs [$];
    result_t want_res;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    relay_open_check_three_phase_sine_ref_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic signed [15:0] sine_value(int unsigned idx);
        longint unsigned t;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned mag;
        longint          sum;
        t = (longint'(idx) << 32) / longint'(DEPTH);
        quad = (t >> 30) & 64'd3;
        r = t & (Q30_ONE - 64'd1);
        if (quad[0])
            r = Q30_ONE - r;
        x = (r * Q30_HALFPI) >> 30;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 5; k++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        mag = (longint'(sum) * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (mag > 64'd32767)
            mag = 64'd32767;
        return quad[1] ? -16'(mag) : 16'(mag);
    endfunction

    function automatic logic signed [15:0] scale_to_vref(logic signed [15:0] s);
        longint scaled;
        longint lim;
        scaled = longint'(amp_cfg) * longint'(s);
        lim = (longint'(period_cfg) - MIN_PULSE_DEF) * 32768;
        if (scaled > lim)
            scaled = lim;
        else if (scaled < -lim)
            scaled = -lim;
        if (scaled > 0)
            return 16'((scaled + 16384) / 32768);
        return -16'((-scaled + 16384) / 32768);
    endfunction

    function automatic result_t predict_tick(sample_t s);
        int      inv [PHASES];
        int      grid [PHASES];
        int      diff;
        int      idx;
        bit      all;
        result_t r;
        inv[0] = s.inv_volt_r;
        inv[1] = s.inv_volt_s;
        inv[2] = s.inv_volt_t;
        grid[0] = s.grid_volt_r;
        grid[1] = s.grid_volt_s;
        grid[2] = s.grid_volt_t;
        all = 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            diff = (inv[p] > grid[p]) ? inv[p] - grid[p] : grid[p] - inv[p];
            if (diff > int'(thr_cfg))
                run_len[p] = run_len[p] + 1;
            else
                run_len[p] = 0;
            if (run_len[p] > COUNT_LIMIT_DEF)
            begin
                run_len[p] = COUNT_LIMIT_DEF + 1;
                open_state[p] = 1'b1;
            end
            all = all & open_state[p];
        end
        if (all)
        begin
            for (int p = 0; p < PHASES; p++)
            begin
                angle[p] = angle[p] + step_cfg;
                idx = (int'(angle[p]) * DEPTH) >> 16;
                held_i[p] = sine_tab[idx];
                held_v[p] = scale_to_vref(held_i[p]);
            end
        end
        r.all_open = all;
        r.open_flags = open_state;
        r.vref_r = held_v[0];
        r.vref_s = held_v[1];
        r.vref_t = held_v[2];
        r.iref_r = held_i[0];
        r.iref_s = held_i[1];
        r.iref_t = held_i[2];
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got %0d, predicted %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_refs.size() == 0)
                note_mismatch("result arrived with no request outstanding");
            else
            begin
                want_res = pending_refs.pop_front();
                check_field("all_open", result.all_open, want_res.all_open);
                check_field("open_flags", result.open_flags, want_res.open_flags);
                check_field("vref_r", result.vref_r, want_res.vref_r);
                check_field("vref_s", result.vref_s, want_res.vref_s);
                check_field("vref_t", result.vref_t, want_res.vref_t);
                check_field("iref_r", result.iref_r, want_res.iref_r);
                check_field("iref_s", result.iref_s, want_res.iref_s);
                check_field("iref_t", result.iref_t, want_res.iref_t);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_sample(sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        pending_refs.push_back(predict_tick(s));
    endtask

    task automatic send_voltages(int ir, int is, int it, int gr, int gs, int gt);
        sample_t s;
        s.inv_volt_r = 16'(ir);
        s.inv_volt_s = 16'(is);
        s.inv_volt_t = 16'(it);
        s.grid_volt_r = 16'(gr);
        s.grid_volt_s = 16'(gs);
        s.grid_volt_t = 16'(gt);
        send_sample(s);
    endtask

    function automatic void pick_pair(bit above, output int inv, output int grid);
        int d;
        inv = int'($urandom_range(65535)) - 32768;
        if ($urandom_range(7) == 0)
        begin
            d = above ? int'(thr_cfg) + 1 : int'(thr_cfg);
            grid = (inv + d <= 32767) ? inv + d : inv - d;
        end
        else if (above)
        begin
            do
            begin
                inv = int'($urandom_range(65535)) - 32768;
                grid = int'($urandom_range(65535)) - 32768;
            end
            while (((inv > grid) ? inv - grid : grid - inv) <= int'(thr_cfg));
        end
        else
        begin
            d = int'($urandom_range(int'(thr_cfg)));
            if ($urandom_range(1) == 1)
                d = -d;
            grid = inv + d;
            if (grid > 32767)
                grid = 32767;
            if (grid < -32768)
                grid = -32768;
        end
    endfunction

    task automatic send_tick(bit [2:0] above);
        int inv [PHASES];
        int grid [PHASES];
        for (int p = 0; p < PHASES; p++)
            pick_pair(above[p], inv[p], grid[p]);
        send_voltages(inv[0], inv[1], inv[2], grid[0], grid[1], grid[2]);
    endtask

    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending_refs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(int thr, int period, int amp, int step);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx = '{CFG_RELAY_VOLT_THRESHOLD, CFG_PWM_PERIOD, CFG_VOLTAGE_AMPLITUDE, CFG_ANGLE_STEP};
        val = '{16'(thr), 16'(period), 16'(amp), 16'(step)};
        wait_idle();
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx[i])
                CFG_RELAY_VOLT_THRESHOLD: thr_cfg = val[i][14:0];
                CFG_PWM_PERIOD:           period_cfg = val[i][14:0];
                CFG_VOLTAGE_AMPLITUDE:    amp_cfg = val[i][14:0];
                CFG_ANGLE_STEP:           step_cfg = val[i];
                default:                  ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_run(bit [2:0] above, int n);
        repeat (n) send_tick(above);
    endtask

    task automatic test_directed();
        send_voltages(0, 0, 0, 0, 0, 0);
        send_voltages(32767, -32768, 500, -32768, 32767, 0);
        send_voltages(32767, -32768, -32267, -32768, 32767, -32768);
        send_voltages(-32768, -32768, -32768, 32767, 32767, 32767);
        send_voltages(32767, 32767, 32767, 32767, 32767, 32767);
        send_voltages(-32768, -32768, -32768, -32768, -32768, -32768);
        set_regs(0, PERIOD_RESET, AMPLITUDE_RESET, STEP_RESET);
        send_voltages(0, 123, -4567, 0, 123, -4567);
        send_voltages(1, -32768, 32767, 0, -32767, 32766);
        set_regs(32767, PERIOD_RESET, AMPLITUDE_RESET, STEP_RESET);
        send_voltages(32767, 0, -1, 0, -32768, 32766);
        send_voltages(-32768, 32767, 16384, 32767, -32768, -16384);
        set_regs(THRESHOLD_RESET, PERIOD_RESET, AMPLITUDE_RESET, STEP_RESET);
    endtask

    task automatic test_counter_runs();
        repeat (80) send_tick(3'($urandom_range(7)));
        send_run(3'b001, COUNT_LIMIT_DEF);
        send_run(3'b000, 1);
        send_run(3'b111, COUNT_LIMIT_DEF);
        send_run(3'b000, 1);
        send_run(3'b001, $urandom_range(20, COUNT_LIMIT_DEF - 1));
        send_run(3'b110, 1);
    endtask

    task automatic test_phase_opening();
        set_regs($urandom_range(1000), PERIOD_RESET, AMPLITUDE_RESET, STEP_RESET);
        send_run(3'b001, COUNT_LIMIT_DEF + 1 + $urandom_range(3));
        repeat (20) send_tick(3'($urandom_range(7)));
        send_run(3'b010, COUNT_LIMIT_DEF + 1);
        send_run(3'b000, 1);
        send_run(3'b100, COUNT_LIMIT_DEF + 2 + $urandom_range(3));
    endtask

    task automatic run_setting(int thr, int period, int amp, int step, int n);
        set_regs(thr, period, amp, step);
        repeat (n) send_tick(3'($urandom_range(7)));
    endtask

    task automatic test_reference_extremes();
        run_setting(THRESHOLD_RESET, PERIOD_RESET, AMPLITUDE_RESET, STEP_RESET, 35);
        run_setting(0, 32767, 32767, 65535, 35);
        run_setting(32767, 16, 32767, 1, 35);
        run_setting($urandom_range(32767), 16, 0, $urandom_range(1, 65535), 35);
        run_setting($urandom_range(32767), 1000, 32767, $urandom_range(1, 65535), 35);
        run_setting($urandom_range(32767), 32767, 1, 16384, 35);
    endtask

    task automatic test_reference_random(int settings);
        repeat (settings)
            run_setting($urandom_range(32767), $urandom_range(16, 32767),
                        $urandom_range(32767), $urandom_range(1, 65535), 35);
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_request = 300;
        repeat (60) send_tick(3'($urandom_range(7)));
        wait_idle();
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            sine_tab[i] = sine_value(i);
        thr_cfg = THRESHOLD_RESET;
        period_cfg = PERIOD_RESET;
        amp_cfg = AMPLITUDE_RESET;
        step_cfg = STEP_RESET;
        open_state = '0;
        for (int p = 0; p < PHASES; p++)
        begin
            run_len[p] = 0;
            angle[p] = ACC_RESET[p];
            held_v[p] = '0;
            held_i[p] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 25;
        recv_idle_pct = 67;
        test_directed();
        test_counter_runs();

        send_idle_pct = 67;
        recv_idle_pct = 25;
        test_phase_opening();
        test_reference_extremes();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_reference_random(6);
        test_backpressure();

        wait_idle();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
